[design/direction_to_pitch_yaw_defines.svh]
// Assertion macros for the direction-to-pitch/yaw block.
// Used by the top level; no other dependencies.
`ifndef DIRECTION_TO_PITCH_YAW_DEFINES_SVH
`define DIRECTION_TO_PITCH_YAW_DEFINES_SVH
`ifndef SYNTH
// The condition must never be seen at a clock edge outside reset.
`define DTPY_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("dtpy: forbidden condition seen");
// The consequent must hold in the same cycle as the antecedent.
`define DTPY_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtpy: implication failed");
// The consequent must hold in the cycle after the antecedent.
`define DTPY_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtpy: next-cycle implication failed");
`else
`define DTPY_ASSERT_NEVER(label, clk, rst, cond)
`define DTPY_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DTPY_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[design/dtpy_pkg.sv]
// Shared types, constants and the arctangent table of the direction-to-pitch/yaw block.
// No dependencies; used by the CORDIC pipeline and the top level.
package dtpy_pkg;

   localparam int COORD_WIDTH     = 24;
   localparam int CORDIC_STEPS    = 24;
   localparam int ANGLE_FRAC_BITS = 16;

   // Coordinates are scaled up by the guard bits; four more bits cover CORDIC growth.
   localparam int GUARD_BITS  = 24;
   localparam int LANE_WIDTH  = COORD_WIDTH + GUARD_BITS + 4;
   localparam int TURN_WIDTH  = 32;
   localparam int ANGLE_WIDTH = 9 + ANGLE_FRAC_BITS;

   // CORDIC gain in Q24, positive and narrow enough to be read as signed.
   localparam int GAIN_WIDTH = 26;
   localparam logic [GAIN_WIDTH-1:0] GAIN_Q24 = 26'd27628053;

   localparam logic [TURN_WIDTH-1:0] HALF_TURN = 32'h8000_0000;

   // Turns to degrees: (turns * 45 * 2^F + 2^28) >> 29, with the 2^F folded in.
   localparam int DEG_PER_EIGHTH = 45;
   localparam int DEG_WIDTH      = TURN_WIDTH + 7;
   localparam int DEG_SHIFT      = 29 - ANGLE_FRAC_BITS;
   localparam int DEG_OUT_WIDTH  = DEG_WIDTH - DEG_SHIFT;
   localparam logic [DEG_WIDTH-1:0] DEG_ROUND = DEG_WIDTH'(1) << (DEG_SHIFT - 1);

   localparam logic [ANGLE_WIDTH-1:0] FULL_CIRCLE = ANGLE_WIDTH'(360) << ANGLE_FRAC_BITS;
   localparam logic [ANGLE_WIDTH-1:0] PITCH_UP    = ANGLE_WIDTH'(270) << ANGLE_FRAC_BITS;
   localparam logic [ANGLE_WIDTH-1:0] PITCH_DOWN  = ANGLE_WIDTH'(90) << ANGLE_FRAC_BITS;

   // Output skid buffer.
   localparam int SKID_DEPTH = 2;
   localparam int SKID_COUNT_WIDTH = $clog2(SKID_DEPTH + 1);

   // atan(2^-i) in binary turns (2^32 is a full circle), rounded to nearest.
   localparam logic [TURN_WIDTH-1:0] ATAN_TURNS [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [LANE_WIDTH-1:0]  lane_type;
   typedef logic [TURN_WIDTH-1:0]         turns_type;
   typedef logic [ANGLE_WIDTH-1:0]        angle_type;

   typedef struct packed {
      coord_type dir_x;
      coord_type dir_y;
      coord_type dir_z;
   } dir_req_type;

   typedef struct packed {
      angle_type yaw_angle;
      angle_type pitch_angle;
   } pitch_yaw_rsp_type;

   // Data that rides alongside a CORDIC pipeline.
   typedef struct packed {
      logic      degenerate;
      logic      z_positive;
      turns_type yaw_turns;
      coord_type dir_z;
   } side_type;

endpackage

[design/dtpy_cordic.sv]
// Pipelined vectoring CORDIC: one register stage per micro-rotation.
// Depends on dtpy_pkg for lane types, the step count and the arctangent table.
module dtpy_cordic
   import dtpy_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      in_valid,
   input  lane_type  in_x,
   input  lane_type  in_y,
   input  turns_type in_acc,
   input  side_type  in_side,
   output logic      out_valid,
   output lane_type  out_x,
   output turns_type out_acc,
   output side_type  out_side
);

   logic      valid_src [CORDIC_STEPS];
   lane_type  x_src     [CORDIC_STEPS];
   lane_type  y_src     [CORDIC_STEPS];
   turns_type acc_src   [CORDIC_STEPS];
   side_type  side_src  [CORDIC_STEPS];

   lane_type  x_in   [CORDIC_STEPS];
   lane_type  y_in   [CORDIC_STEPS];
   turns_type acc_in [CORDIC_STEPS];

   logic      valid_ff [CORDIC_STEPS];
   lane_type  x_ff     [CORDIC_STEPS];
   lane_type  y_ff     [CORDIC_STEPS];
   turns_type acc_ff   [CORDIC_STEPS];
   side_type  side_ff  [CORDIC_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      // Stage i takes the entry operands or the previous stage.
      if (i == 0) begin : g_first
         assign valid_src[i] = in_valid;
         assign x_src[i]     = in_x;
         assign y_src[i]     = in_y;
         assign acc_src[i]   = in_acc;
         assign side_src[i]  = in_side;
      end else begin : g_next
         assign valid_src[i] = valid_ff[i-1];
         assign x_src[i]     = x_ff[i-1];
         assign y_src[i]     = y_ff[i-1];
         assign acc_src[i]   = acc_ff[i-1];
         assign side_src[i]  = side_ff[i-1];
      end

      // Rotate toward the x axis by atan(2^-i); the shifts floor negative values.
      always_comb begin
         if (!y_src[i][LANE_WIDTH-1]) begin
            x_in[i]   = x_src[i] + (y_src[i] >>> i);
            y_in[i]   = y_src[i] - (x_src[i] >>> i);
            acc_in[i] = acc_src[i] + ATAN_TURNS[i];
         end else begin
            x_in[i]   = x_src[i] - (y_src[i] >>> i);
            y_in[i]   = y_src[i] + (x_src[i] >>> i);
            acc_in[i] = acc_src[i] - ATAN_TURNS[i];
         end
      end

      // Valid bit of the stage.
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (advance) begin
            valid_ff[i] <= valid_src[i];
         end
      end

      // Stage payload.
      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i]    <= x_in[i];
            y_ff[i]    <= y_in[i];
            acc_ff[i]  <= acc_in[i];
            side_ff[i] <= side_src[i];
         end
      end
   end

   assign out_valid = valid_ff[CORDIC_STEPS-1];
   assign out_x     = x_ff[CORDIC_STEPS-1];
   assign out_acc   = acc_ff[CORDIC_STEPS-1];
   assign out_side  = side_ff[CORDIC_STEPS-1];

endmodule

[design/direction_to_pitch_yaw.sv]
// Top level of the direction-to-pitch/yaw block: entry stage, two CORDIC pipelines,
// degree conversion and output skid buffer. Depends on dtpy_pkg, dtpy_cordic and
// direction_to_pitch_yaw_defines.svh.
//
// Usage:
//   A beat on the req channel carries one direction (dir_x, dir_y, dir_z). A beat on
//   the rsp channel returns yaw = atan2(y, x) and pitch = atan2(-z, |(x, y)|) in
//   unsigned Q9.16 degrees wrapped into [0, 360). A vector with x and y both zero
//   gives yaw 0 and pitch 270 (z positive) or 90 (otherwise).
//   Path: a request beat passes the entry stage, 24 yaw CORDIC stages, the z
//   scaling stage, 24 pitch CORDIC stages, two conversion stages and the skid
//   buffer before its result is offered. Throughput: one beat per cycle while the
//   skid buffer has a free entry, set by the one-stage-per-rotation pipelines.
//   Stalls: a two-entry skid buffer holds finished results. The pipeline keeps
//   moving and req_stall stays low until both entries are full; then the whole
//   pipeline holds, and req_stall is decoded from the registered entry count alone.
//   Reset: synchronous and active high; it empties the pipeline and the buffer.
`include "direction_to_pitch_yaw_defines.svh"
module direction_to_pitch_yaw
   import dtpy_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dir_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pitch_yaw_rsp_type rsp_data
);

   logic advance;

   // Entry stage.
   logic      s0_valid_ff;
   lane_type  s0_x_ff, s0_x_in;
   lane_type  s0_y_ff, s0_y_in;
   turns_type s0_acc_ff, s0_acc_in;
   side_type  s0_side_ff, s0_side_in;
   lane_type  x_scaled, y_scaled;

   // Yaw CORDIC outputs.
   logic      c1_valid;
   lane_type  c1_x;
   turns_type c1_acc;
   side_type  c1_side;

   // Z scaling stage.
   logic                      jn_valid_ff;
   lane_type                  jn_x_ff;
   lane_type                  jn_y_ff, jn_y_in;
   side_type                  jn_side_ff, jn_side_in;
   logic signed [COORD_WIDTH:0] neg_z;

   // Pitch CORDIC outputs.
   logic      c2_valid;
   turns_type c2_acc;
   side_type  c2_side;

   // Conversion stages.
   logic                 cv1_valid_ff;
   logic [DEG_WIDTH-1:0] cv1_yaw_ff, cv1_yaw_in;
   logic [DEG_WIDTH-1:0] cv1_pitch_ff, cv1_pitch_in;
   logic                 cv1_degenerate_ff;
   logic                 cv1_z_positive_ff;
   logic                 cv2_valid_ff;
   pitch_yaw_rsp_type    cv2_data_ff, cv2_data_in;

   // Skid buffer.
   logic [SKID_COUNT_WIDTH-1:0] skid_count_ff, skid_count_in;
   pitch_yaw_rsp_type           slot0_ff, slot0_in;
   pitch_yaw_rsp_type           slot1_ff, slot1_in;
   logic                        push, pop;

   // Range check of the offered beat.
   logic rsp_in_range;

   function automatic angle_type wrap_degrees(input logic [DEG_WIDTH-1:0] scaled);
      logic [DEG_OUT_WIDTH-1:0] deg;
      deg = scaled[DEG_WIDTH-1:DEG_SHIFT];
      if (deg >= DEG_OUT_WIDTH'(FULL_CIRCLE)) begin
         deg = deg - DEG_OUT_WIDTH'(FULL_CIRCLE);
      end
      return ANGLE_WIDTH'(deg);
   endfunction

   // The pipeline moves as a whole while the skid buffer has a free entry.
   assign advance   = (skid_count_ff != SKID_COUNT_WIDTH'(SKID_DEPTH));
   assign req_stall = !advance;

   // Scale to the lane format and fold the left half plane onto the right one.
   always_comb begin
      x_scaled = {{(LANE_WIDTH-COORD_WIDTH-GUARD_BITS){req_data.dir_x[COORD_WIDTH-1]}},
                  req_data.dir_x, {GUARD_BITS{1'b0}}};
      y_scaled = {{(LANE_WIDTH-COORD_WIDTH-GUARD_BITS){req_data.dir_y[COORD_WIDTH-1]}},
                  req_data.dir_y, {GUARD_BITS{1'b0}}};
      if (req_data.dir_x[COORD_WIDTH-1]) begin
         s0_x_in   = -x_scaled;
         s0_y_in   = -y_scaled;
         s0_acc_in = HALF_TURN;
      end else begin
         s0_x_in   = x_scaled;
         s0_y_in   = y_scaled;
         s0_acc_in = '0;
      end
      s0_side_in.degenerate = (req_data.dir_x == '0) && (req_data.dir_y == '0);
      s0_side_in.z_positive = !req_data.dir_z[COORD_WIDTH-1] && (req_data.dir_z != '0);
      s0_side_in.yaw_turns  = '0;
      s0_side_in.dir_z      = req_data.dir_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_x_ff    <= s0_x_in;
         s0_y_ff    <= s0_y_in;
         s0_acc_ff  <= s0_acc_in;
         s0_side_ff <= s0_side_in;
      end
   end

   // Yaw CORDIC: leaves K times the planar magnitude in x.
   dtpy_cordic u_yaw_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s0_valid_ff),
      .in_x      (s0_x_ff),
      .in_y      (s0_y_ff),
      .in_acc    (s0_acc_ff),
      .in_side   (s0_side_ff),
      .out_valid (c1_valid),
      .out_x     (c1_x),
      .out_acc   (c1_acc),
      .out_side  (c1_side)
   );

   // Scale -z by the CORDIC gain so that both pitch operands match.
   always_comb begin
      neg_z   = -$signed({c1_side.dir_z[COORD_WIDTH-1], c1_side.dir_z});
      jn_y_in = lane_type'(neg_z) * lane_type'(GAIN_Q24);
      jn_side_in.degenerate = c1_side.degenerate;
      jn_side_in.z_positive = c1_side.z_positive;
      jn_side_in.yaw_turns  = c1_acc;
      jn_side_in.dir_z      = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jn_valid_ff <= 1'b0;
      end else if (advance) begin
         jn_valid_ff <= c1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         jn_x_ff    <= c1_x;
         jn_y_ff    <= jn_y_in;
         jn_side_ff <= jn_side_in;
      end
   end

   // Pitch CORDIC, carrying the yaw angle alongside.
   dtpy_cordic u_pitch_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (jn_valid_ff),
      .in_x      (jn_x_ff),
      .in_y      (jn_y_ff),
      .in_acc    ('0),
      .in_side   (jn_side_ff),
      .out_valid (c2_valid),
      .out_x     (),
      .out_acc   (c2_acc),
      .out_side  (c2_side)
   );

   // Turns times 45, plus the rounding half.
   always_comb begin
      cv1_yaw_in   = DEG_WIDTH'(c2_side.yaw_turns) * DEG_WIDTH'(DEG_PER_EIGHTH) + DEG_ROUND;
      cv1_pitch_in = DEG_WIDTH'(c2_acc) * DEG_WIDTH'(DEG_PER_EIGHTH) + DEG_ROUND;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv1_valid_ff <= 1'b0;
         cv2_valid_ff <= 1'b0;
      end else if (advance) begin
         cv1_valid_ff <= c2_valid;
         cv2_valid_ff <= cv1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cv1_yaw_ff        <= cv1_yaw_in;
         cv1_pitch_ff      <= cv1_pitch_in;
         cv1_degenerate_ff <= c2_side.degenerate;
         cv1_z_positive_ff <= c2_side.z_positive;
         cv2_data_ff       <= cv2_data_in;
      end
   end

   // Drop the fraction, wrap a full circle to zero and apply the zero-plane case.
   always_comb begin
      if (cv1_degenerate_ff) begin
         cv2_data_in.yaw_angle   = '0;
         cv2_data_in.pitch_angle = cv1_z_positive_ff ? PITCH_UP : PITCH_DOWN;
      end else begin
         cv2_data_in.yaw_angle   = wrap_degrees(cv1_yaw_ff);
         cv2_data_in.pitch_angle = wrap_degrees(cv1_pitch_ff);
      end
   end

   // Skid buffer: slot0 is the head beat offered on rsp.
   assign push = advance && cv2_valid_ff;
   assign pop  = rsp_valid && !rsp_stall;

   always_comb begin
      slot0_in      = slot0_ff;
      slot1_in      = slot1_ff;
      skid_count_in = skid_count_ff;
      if (push && pop) begin
         if (skid_count_ff == SKID_COUNT_WIDTH'(1)) begin
            slot0_in = cv2_data_ff;
         end else begin
            slot0_in = slot1_ff;
            slot1_in = cv2_data_ff;
         end
      end else if (pop) begin
         slot0_in      = slot1_ff;
         skid_count_in = skid_count_ff - SKID_COUNT_WIDTH'(1);
      end else if (push) begin
         if (skid_count_ff == '0) begin
            slot0_in = cv2_data_ff;
         end else begin
            slot1_in = cv2_data_ff;
         end
         skid_count_in = skid_count_ff + SKID_COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_count_ff <= '0;
      end else begin
         skid_count_ff <= skid_count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_valid = (skid_count_ff != '0);
   assign rsp_data  = slot0_ff;

   assign rsp_in_range = (rsp_data.yaw_angle < FULL_CIRCLE) &&
                         (rsp_data.pitch_angle < FULL_CIRCLE);

   // The skid buffer never holds more beats than it has entries.
   `DTPY_ASSERT_NEVER(a_skid_count, clock, reset, skid_count_ff > SKID_COUNT_WIDTH'(SKID_DEPTH))
   // Both angles offered on rsp lie below a full circle.
   `DTPY_ASSERT_IMPLY(a_angle_range, clock, reset, rsp_valid, rsp_in_range)
   // A held pipeline keeps its finished beat instead of dropping it.
   `DTPY_ASSERT_NEXT(a_hold_last, clock, reset, !advance && cv2_valid_ff, cv2_valid_ff)

endmodule

[tb/direction_to_pitch_yaw_tb.sv]
// Self-checking testbench for direction_to_pitch_yaw: random and corner-case directions
// in, bit-exact yaw/pitch predictions compared against every response beat.
// Depends on dtpy_pkg and the direction_to_pitch_yaw RTL.
module direction_to_pitch_yaw_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dtpy_pkg::*;

   localparam int RANDOM_DIRS  = 1600;
   localparam int RESET_CYCLES = 11;
   localparam int QUIET_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 60;
   localparam int REPORT_LIMIT = 10;
   localparam int PHASES       = 4;
   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   // Idle and stall rates per phase: none, sender only, receiver only, both.
   localparam int SEND_IDLE_PCT [PHASES] = '{0, 54, 0, 22};
   localparam int RSP_STALL_PCT [PHASES] = '{0, 0, 54, 22};

   typedef struct {
      dir_req_type       dir;
      pitch_yaw_rsp_type angles;
   } pending_angles_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   dir_req_type       req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   pitch_yaw_rsp_type rsp_data;

   dir_req_type        dirs_to_send [$];
   pending_angles_type angles_due [$];
   int total_dirs     = 0;
   int dirs_taken     = 0;
   int quiet_cycles   = 0;
   int mismatch_count = 0;

   direction_to_pitch_yaw i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The idling phase follows how far the request stream has got.
   function automatic int idle_phase();
      int p;
      p = (total_dirs == 0) ? 0 : dirs_taken * PHASES / total_dirs;
      return (p > PHASES - 1) ? PHASES - 1 : p;
   endfunction

   // Vectoring CORDIC: drives vy toward zero, accumulating the turned angle in binary
   // turns. vx ends as the gain-scaled magnitude.
   function automatic turns_type cordic_vector(inout longint vx, input longint vy,
                                               input turns_type start);
      turns_type acc;
      longint    dx;
      longint    dy;
      int        i;
      acc = start;
      for (i = 0; i < CORDIC_STEPS && i < TURN_WIDTH; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (vy >= 0) begin
            vx += dx;
            vy -= dy;
            acc += ATAN_TURNS[i];
         end else begin
            vx -= dx;
            vy += dy;
            acc -= ATAN_TURNS[i];
         end
      end
      return acc;
   endfunction

   // Binary turns to Q9.F degrees, rounded half up; a full circle folds back to zero.
   function automatic angle_type turns_to_angle(turns_type t);
      logic [63:0] deg;
      deg = ((64'(t) * DEG_PER_EIGHTH) << ANGLE_FRAC_BITS) + (64'd1 << 28);
      deg = deg >> 29;
      if (deg >= 64'(FULL_CIRCLE))
         deg -= 64'(FULL_CIRCLE);
      return angle_type'(deg);
   endfunction

   function automatic pitch_yaw_rsp_type predict_angles(dir_req_type d);
      pitch_yaw_rsp_type r;
      coord_type         cx;
      coord_type         cy;
      coord_type         cz;
      longint            x;
      longint            y;
      longint            z;
      longint            mag;
      turns_type         yaw_turns;
      turns_type         pitch_turns;
      cx = d.dir_x;
      cy = d.dir_y;
      cz = d.dir_z;
      x = cx;
      y = cy;
      z = cz;
      if (x == 0 && y == 0) begin
         // Straight up or down: yaw is meaningless and reported as zero.
         r.yaw_angle   = '0;
         r.pitch_angle = (z > 0) ? PITCH_UP : PITCH_DOWN;
      end else begin
         x = x <<< GUARD_BITS;
         y = y <<< GUARD_BITS;
         yaw_turns = '0;
         // Left half plane: turn by half a circle first.
         if (x < 0) begin
            x = -x;
            y = -y;
            yaw_turns = HALF_TURN;
         end
         yaw_turns = cordic_vector(x, y, yaw_turns);
         // z gets the CORDIC gain so both pitch operands share one scale.
         mag = x;
         pitch_turns = cordic_vector(mag, -z * longint'(GAIN_Q24), '0);
         r.yaw_angle   = turns_to_angle(yaw_turns);
         r.pitch_angle = turns_to_angle(pitch_turns);
      end
      return r;
   endfunction

   function automatic coord_type random_coord();
      coord_type v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: v = COORD_MAX;
               1: v = COORD_MIN;
               2: v = '0;
               3: v = 1;
               default: v = -1;
            endcase
         end
         1, 2: v = coord_type'(int'($urandom_range(0, 2000)) - 1000);
         3, 4, 5: v = coord_type'($urandom) >>> $urandom_range(0, COORD_WIDTH - 2);
         default: v = coord_type'($urandom);
      endcase
      return v;
   endfunction

   task automatic queue_dir(coord_type x, coord_type y, coord_type z);
      dir_req_type d;
      d.dir_x = x;
      d.dir_y = y;
      d.dir_z = z;
      dirs_to_send.push_back(d);
   endtask

   // Stimulus, reset and end of run.
   initial begin
      int n;
      int pick;
      // Vertical vectors, including z zero, which counts as looking down.
      queue_dir(0, 0, 0);
      queue_dir(0, 0, 1);
      queue_dir(0, 0, -1);
      queue_dir(0, 0, COORD_MAX);
      queue_dir(0, 0, COORD_MIN);
      // Axis directions and the left half plane.
      queue_dir(1, 0, 0);
      queue_dir(-1, 0, 0);
      queue_dir(0, 1, 0);
      queue_dir(0, -1, 0);
      queue_dir(COORD_MIN, 0, 0);
      queue_dir(COORD_MIN, -1, 0);
      queue_dir(COORD_MIN, 1, 0);
      queue_dir(-1, 1, 0);
      queue_dir(-1, -1, 1);
      // Field extremes.
      queue_dir(COORD_MAX, COORD_MAX, COORD_MAX);
      queue_dir(COORD_MIN, COORD_MIN, COORD_MIN);
      queue_dir(COORD_MIN, COORD_MAX, COORD_MIN);
      queue_dir(COORD_MAX, COORD_MIN, COORD_MAX);
      // Angles close to an axis, some just short of a full circle, which may round up to zero.
      queue_dir(COORD_MAX, -1, 0);
      queue_dir(COORD_MAX, 0, 1);
      queue_dir(COORD_MAX, 0, -1);
      queue_dir(1, 1, COORD_MIN);
      queue_dir(1, 0, COORD_MAX);
      for (n = 0; n < RANDOM_DIRS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8)
            queue_dir(0, 0, random_coord());
         else if (pick < 12)
            queue_dir(0, random_coord(), random_coord());
         else if (pick < 16)
            queue_dir(random_coord(), 0, random_coord());
         else
            queue_dir(random_coord(), random_coord(), random_coord());
      end
      total_dirs = dirs_to_send.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last request beat and its response, then let the pipeline drain.
      while (dirs_to_send.size() != 0 || req_valid)
         @(posedge clock);
      while (angles_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && angles_due.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Request driver: a stalled beat is held; otherwise the next direction goes out
   // unless the sender idles this cycle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (dirs_to_send.size() != 0 &&
             $urandom_range(0, 99) >= SEND_IDLE_PCT[idle_phase()]) begin
            req_valid <= 1'b1;
            req_data  <= dirs_to_send.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: predicts each request beat, checks each response beat in order and
   // drives the response stall.
   always @(posedge clock) begin : monitor_proc
      pending_angles_type due;
      logic               req_fire;
      logic               rsp_fire;
      req_fire = req_valid && !req_stall;
      rsp_fire = rsp_valid && !rsp_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (req_fire) begin
            due.dir    = req_data;
            due.angles = predict_angles(req_data);
            angles_due.push_back(due);
            dirs_taken <= dirs_taken + 1;
         end
         if (rsp_fire) begin
            if (angles_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: unexpected response beat yaw %0d pitch %0d", $realtime,
                           rsp_data.yaw_angle, rsp_data.pitch_angle);
            end else begin
               due = angles_due.pop_front();
               if (rsp_data.yaw_angle !== due.angles.yaw_angle ||
                   rsp_data.pitch_angle !== due.angles.pitch_angle) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("%0t: dir (%0d, %0d, %0d) yaw exp %0d got %0d, pitch exp %0d got %0d",
                              $realtime, due.dir.dir_x, due.dir.dir_y, due.dir.dir_z,
                              due.angles.yaw_angle, rsp_data.yaw_angle,
                              due.angles.pitch_angle, rsp_data.pitch_angle);
               end
            end
         end
         quiet_cycles <= (req_fire || rsp_fire) ? 0 : quiet_cycles + 1;
         rsp_stall <= ($urandom_range(0, 99) < RSP_STALL_PCT[idle_phase()]);
      end
   end

   // Watchdog: too long without a beat on either channel ends the run.
   initial begin
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
